// ===== hw/rtl/imm_pkg.sv =====
package imm_pkg;

    localparam int MAX_DIM_DEFAULT = 16;
    localparam int RESULT_LIMIT    = 16;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int DIM_W  = 5;
    localparam int OP_W   = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_ROW    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } imm_state_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/imm_cmd_if.sv =====
interface imm_cmd_if;
    import imm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;

    modport source (output valid, output opcode, output row_index, output col_index,
                    output element_value, input ready);
    modport sink   (input valid, input opcode, input row_index, input col_index,
                    input element_value, output ready);
endinterface

// ===== hw/rtl/imm_result_if.sv =====
interface imm_result_if;
    import imm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] product_value;
    logic [IDX_W-1:0]         result_column;
    logic                     last_of_row;

    modport source (output valid, output product_value, output result_column,
                    output last_of_row, input ready);
    modport sink   (input valid, input product_value, input result_column,
                    input last_of_row, output ready);
endinterface

// ===== hw/rtl/imm_cfg_if.sv =====
interface imm_cfg_if;
    import imm_pkg::*;

    logic             valid;
    logic             ready;
    logic [DIM_W-1:0] dim_in_use;

    modport source (output valid, output dim_in_use, input ready);
    modport sink   (input valid, input dim_in_use, output ready);
endinterface

// ===== hw/rtl/imm_mem.sv =====
module imm_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [imm_pkg::DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [imm_pkg::DATA_W-1:0] rdata
);
    import imm_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/imm_cell.sv =====
module imm_cell (
    input  logic                       clk,
    input  imm_pkg::cell_ctrl_t        ctrl,
    input  logic [imm_pkg::DATA_W-1:0] acc_in,
    input  logic [imm_pkg::DATA_W-1:0] addend,
    output logic [imm_pkg::DATA_W-1:0] acc_out
);
    import imm_pkg::*;

    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.shift)
        begin
            acc_next = acc_in + addend;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc_out = acc_reg;

endmodule

// ===== hw/rtl/integer_matrix_multiply.sv =====
// Loads: one beat per cycle while idle, no result.
// Row request: the first result beat follows the last of n*n products (n = size in use),
// one multiply-accumulate per cycle through the single multiplier, then one result
// beat per cycle while the sink is ready; the next command is taken after the last beat.
// Reset: size in use returns to 16; matrix storage is not cleared.
module integer_matrix_multiply #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    imm_cmd_if.sink      cmd,
    imm_cfg_if.sink      cfg,
    imm_result_if.source result
);
    import imm_pkg::*;

    localparam int NC      = (MAX_DIM < RESULT_LIMIT) ? MAX_DIM : RESULT_LIMIT;
    localparam int CIDX_W  = (NC > 1) ? $clog2(NC) : 1;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    imm_state_t state_reg, state_next;

    logic [DIM_W-1:0]  dim_reg;
    logic [DIM_W-1:0]  eff_dim;
    logic [IDX_W-1:0]  last_idx;
    logic [CIDX_W-1:0] tail_idx;

    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  l_reg;
    logic [IDX_W-1:0]  j_reg;
    logic              issue_reg;
    logic              iss_last;
    logic [IDX_W-1:0]  emit_col_reg;

    logic              rd_valid_reg, rd_last_reg;
    logic              prod_valid_reg, prod_last_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] mul_lo;

    logic              cmd_fire, res_fire, start, addr_ok;
    logic              we_a, we_b;
    logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
    logic [DATA_W-1:0] a_data, b_data;

    cell_ctrl_t        cell_ctrl;
    logic [DATA_W-1:0] cell_q [NC];

    // Size in use, clamped to the supported range
    always_comb
    begin
        if (dim_reg == '0)
        begin
            eff_dim = DIM_W'(1);
        end
        else if (int'(dim_reg) > NC)
        begin
            eff_dim = DIM_W'(NC);
        end
        else
        begin
            eff_dim = dim_reg;
        end
    end

    assign last_idx = IDX_W'(eff_dim - DIM_W'(1));
    assign tail_idx = CIDX_W'(eff_dim - DIM_W'(1));

    assign cmd_fire = cmd.valid && cmd.ready;
    assign res_fire = result.valid && result.ready;
    assign addr_ok  = (int'(cmd.row_index) < MAX_DIM) && (int'(cmd.col_index) < MAX_DIM);
    assign we_a     = cmd_fire && (cmd.opcode == OP_LOAD_A) && addr_ok;
    assign we_b     = cmd_fire && (cmd.opcode == OP_LOAD_B) && addr_ok;
    assign start    = cmd_fire && (cmd.opcode == OP_ROW)
                      && ({1'b0, cmd.row_index} < eff_dim);
    assign iss_last = (l_reg == last_idx) && (j_reg == last_idx);

    assign waddr   = ADDR_W'(int'(cmd.row_index) * MAX_DIM + int'(cmd.col_index));
    assign a_raddr = ADDR_W'(int'(row_reg) * MAX_DIM + int'(l_reg));
    assign b_raddr = ADDR_W'(int'(l_reg) * MAX_DIM + int'(j_reg));

    imm_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (cmd.element_value),
        .raddr (a_raddr),
        .rdata (a_data)
    );

    imm_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (cmd.element_value),
        .raddr (b_raddr),
        .rdata (b_data)
    );

    // Low word of the product is all the wrapped sum needs
    assign mul_lo = a_data * b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            dim_reg        <= DIM_RESET;
            issue_reg      <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            l_reg          <= '0;
            j_reg          <= '0;
            row_reg        <= '0;
            emit_col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                dim_reg <= cfg.dim_in_use;
            end

            if (start)
            begin
                row_reg   <= cmd.row_index;
                l_reg     <= '0;
                j_reg     <= '0;
                issue_reg <= 1'b1;
            end
            else if (issue_reg)
            begin
                if (j_reg == last_idx)
                begin
                    j_reg <= '0;
                    l_reg <= l_reg + IDX_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                end
                if (iss_last)
                begin
                    issue_reg <= 1'b0;
                end
            end

            rd_valid_reg   <= issue_reg;
            rd_last_reg    <= issue_reg && iss_last;
            prod_valid_reg <= rd_valid_reg;
            prod_last_reg  <= rd_last_reg;

            if (start)
            begin
                emit_col_reg <= '0;
            end
            else if (res_fire)
            begin
                emit_col_reg <= emit_col_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_lo;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (prod_valid_reg && prod_last_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (res_fire && (emit_col_reg == last_idx))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready       = 1'b0;
        result.valid    = 1'b0;
        cell_ctrl.clear = 1'b0;
        cell_ctrl.shift = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready       = 1'b1;
                cell_ctrl.clear = start;
            end
            ST_CALC:
            begin
                cell_ctrl.shift = prod_valid_reg;
            end
            ST_EMIT:
            begin
                result.valid    = 1'b1;
                cell_ctrl.shift = result.ready;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    assign cfg.ready = 1'b1;

    // Accumulator ring: cell 0 adds the product, the tail wraps around to cell 0
    genvar k;
    generate
        for (k = 0; k < NC; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                imm_cell u_cell (
                    .clk     (clk),
                    .ctrl    (cell_ctrl),
                    .acc_in  (cell_q[tail_idx]),
                    .addend  (prod_valid_reg ? prod_reg : '0),
                    .acc_out (cell_q[k])
                );
            end
            else
            begin : g_body
                imm_cell u_cell (
                    .clk     (clk),
                    .ctrl    (cell_ctrl),
                    .acc_in  (cell_q[k-1]),
                    .addend  ('0),
                    .acc_out (cell_q[k])
                );
            end
        end
    endgenerate

    assign result.product_value = cell_q[tail_idx];
    assign result.result_column = emit_col_reg;
    assign result.last_of_row   = (emit_col_reg == last_idx);

endmodule

// ===== tb/imm_product_checker.sv =====
module imm_product_checker
    import imm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  logic                     cmd_ready,
    input  logic [OP_W-1:0]          cmd_opcode,
    input  logic [IDX_W-1:0]         cmd_row,
    input  logic [IDX_W-1:0]         cmd_col,
    input  logic [DATA_W-1:0]        cmd_value,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [DIM_W-1:0]         cfg_dim,
    input  logic                     res_valid,
    input  logic                     res_ready,
    input  logic [DATA_W-1:0]        res_value,
    input  logic [IDX_W-1:0]         res_column,
    input  logic                     res_last,
    output int                       mismatches,
    output int                       pending
);

    localparam int SIDE = MAX_DIM_DEFAULT;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  column;
        logic              last;
    } product_beat_t;

    product_beat_t     expected_products[$];
    logic [DATA_W-1:0] left_matrix [SIDE*SIDE];
    logic [DATA_W-1:0] right_matrix [SIDE*SIDE];
    logic [DIM_W-1:0]  size_reg = DIM_RESET;
    int                mismatch_count = 0;
    int                pending_count = 0;

    assign mismatches = mismatch_count;
    assign pending    = pending_count;

    function automatic int effective_size(input logic [DIM_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1)
            n = 1;
        if (n > SIDE)
            n = SIDE;
        if (n > RESULT_LIMIT)
            n = RESULT_LIMIT;
        return n;
    endfunction

    task automatic compute_product_row(input logic [IDX_W-1:0] row);
        int                n;
        logic [DATA_W-1:0] acc;
        product_beat_t     beat;
        n = effective_size(size_reg);
        if (int'(row) < n)
        begin
            for (int j = 0; j < n; j++)
            begin
                acc = '0;
                for (int l = 0; l < n; l++)
                    acc = acc + left_matrix[int'(row)*SIDE + l] * right_matrix[l*SIDE + j];
                beat.value  = acc;
                beat.column = j[IDX_W-1:0];
                beat.last   = (j == n - 1);
                expected_products.push_back(beat);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        product_beat_t beat;
        if (!rst_n)
        begin
            expected_products.delete();
            size_reg = DIM_RESET;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_products.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat: value %0d col %0d last %0b",
                                 $signed(res_value), res_column, res_last);
                end
                else
                begin
                    beat = expected_products.pop_front();
                    if (res_value !== beat.value || res_column !== beat.column ||
                        res_last !== beat.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected value %0d col %0d last %0b, got value %0d col %0d last %0b",
                                     $signed(beat.value), beat.column, beat.last,
                                     $signed(res_value), res_column, res_last);
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                case (cmd_opcode)
                    OP_LOAD_A: left_matrix[{cmd_row, cmd_col}] = cmd_value;
                    OP_LOAD_B: right_matrix[{cmd_row, cmd_col}] = cmd_value;
                    OP_ROW:    compute_product_row(cmd_row);
                    default:   ;
                endcase
            end
            if (cfg_valid && cfg_ready)
                size_reg = cfg_dim;
        end
        pending_count = expected_products.size();
    end

endmodule

// ===== tb/integer_matrix_multiply_test.sv =====
module integer_matrix_multiply_test;
    import imm_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SIDE        = MAX_DIM_DEFAULT;
    localparam int TARGET      = 470;
    localparam int CALM_AFTER  = 420;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 300;

    logic clk;
    logic rst_n;

    imm_cmd_if    cmd_ch ();
    imm_cfg_if    cfg_ch ();
    imm_result_if res_ch ();

    int mismatches;
    int pending;
    int item_count = 0;
    int cur_size = 16;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit wr_left [SIDE*SIDE];
    bit wr_right [SIDE*SIDE];

    integer_matrix_multiply u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .cfg    (cfg_ch),
        .result (res_ch)
    );

    imm_product_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_ch.valid),
        .cmd_ready  (cmd_ch.ready),
        .cmd_opcode (cmd_ch.opcode),
        .cmd_row    (cmd_ch.row_index),
        .cmd_col    (cmd_ch.col_index),
        .cmd_value  (cmd_ch.element_value),
        .cfg_valid  (cfg_ch.valid),
        .cfg_ready  (cfg_ch.ready),
        .cfg_dim    (cfg_ch.dim_in_use),
        .res_valid  (res_ch.valid),
        .res_ready  (res_ch.ready),
        .res_value  (res_ch.product_value),
        .res_column (res_ch.result_column),
        .res_last   (res_ch.last_of_row),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #(12 * 1000000);
        $display("[integer_matrix_multiply] ERROR");
        $finish;
    end

    // result sink: random stall bursts, one long hold-off on request
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic int effective_size(input int v);
        if (v < 1)
            return 1;
        if (v > SIDE)
            return SIDE;
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] rand_element();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return DATA_W'($signed($urandom_range(0, 15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.opcode        <= op;
        cmd_ch.row_index     <= row;
        cmd_ch.col_index     <= col;
        cmd_ch.element_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ch.ready);
        item_count++;
        if (item_count >= CALM_AFTER)
            calm = 1'b1;
    endtask

    task automatic load_elem(input logic [OP_W-1:0] op, input int row, input int col,
                             input logic [DATA_W-1:0] value);
        send_cmd(op, row[IDX_W-1:0], col[IDX_W-1:0], value);
        if (op == OP_LOAD_A)
            wr_left[row*SIDE + col] = 1'b1;
        else
            wr_right[row*SIDE + col] = 1'b1;
    endtask

    task automatic request_row(input int row);
        for (int l = 0; l < cur_size; l++)
            if (!wr_left[row*SIDE + l])
                load_elem(OP_LOAD_A, row, l, rand_element());
        for (int l = 0; l < cur_size; l++)
            for (int j = 0; j < cur_size; j++)
                if (!wr_right[l*SIDE + j])
                    load_elem(OP_LOAD_B, l, j, rand_element());
        send_cmd(OP_ROW, row[IDX_W-1:0], IDX_W'($urandom), $urandom);
    endtask

    task automatic write_size(input int v);
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.dim_in_use <= v[DIM_W-1:0];
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_size = effective_size(v);
    endtask

    task automatic run_phase();
        int len;
        int r;
        int row;
        len = (cur_size >= SIDE) ? 12 : 40;
        for (int k = 0; k < len && item_count < TARGET; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                request_row($urandom_range(0, cur_size - 1));
            else if (r < 35)
            begin
                row = $urandom_range(0, cur_size - 1);
                for (int l = 0; l < cur_size; l++)
                    load_elem(OP_LOAD_A, row, l, rand_element());
                request_row(row);
            end
            else if (r < 40)
            begin
                if (cur_size < SIDE)
                    send_cmd(OP_ROW, IDX_W'($urandom_range(cur_size, SIDE - 1)),
                             IDX_W'($urandom), $urandom);
                else
                    send_cmd(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
            end
            else if (r < 45)
                send_cmd(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
            else if (r < 72)
                load_elem(OP_LOAD_A, $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                          rand_element());
            else
                load_elem(OP_LOAD_B, $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                          rand_element());
        end
    endtask

    initial
    begin
        int size_plan [10];
        int phase;
        int v;
        size_plan = '{3, 4, 1, 31, 2, 0, 5, 16, 6, 17};
        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.opcode        = OP_LOAD_A;
        cmd_ch.row_index     = '0;
        cmd_ch.col_index     = '0;
        cmd_ch.element_value = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.dim_in_use    = DIM_RESET;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: 2x2 with extreme values, out-of-range rows, unused opcode
        write_size(2);
        load_elem(OP_LOAD_A, 0, 0, 32'h7FFF_FFFF);
        load_elem(OP_LOAD_A, 0, 1, 32'h8000_0000);
        load_elem(OP_LOAD_A, 1, 0, 32'hFFFF_FFFF);
        load_elem(OP_LOAD_A, 1, 1, 32'h0000_0001);
        load_elem(OP_LOAD_B, 0, 0, 32'h7FFF_FFFF);
        load_elem(OP_LOAD_B, 0, 1, 32'h8000_0000);
        load_elem(OP_LOAD_B, 1, 0, 32'h8000_0000);
        load_elem(OP_LOAD_B, 1, 1, 32'hFFFF_FFFF);
        send_cmd(OP_ROW, 4'd0, 4'd15, 32'hFFFF_FFFF);
        send_cmd(OP_ROW, 4'd1, 4'd0, 32'h0);
        send_cmd(OP_ROW, 4'd2, 4'd0, 32'h0);
        send_cmd(OP_ROW, 4'd15, 4'd15, 32'h0);
        send_cmd(OP_UNUSED, 4'd0, 4'd0, 32'h0);
        load_elem(OP_LOAD_A, 15, 15, 32'h1234_5678);
        load_elem(OP_LOAD_B, 15, 15, 32'hFEDC_BA98);
        load_elem(OP_LOAD_A, 0, 1, 32'h0);
        send_cmd(OP_ROW, 4'd0, 4'd0, 32'h0);
        write_size(0);
        send_cmd(OP_ROW, 4'd0, 4'd0, 32'h0);
        send_cmd(OP_ROW, 4'd1, 4'd0, 32'h0);
        write_size(1);
        send_cmd(OP_ROW, 4'd0, 4'd7, 32'h0);

        phase = 0;
        while (item_count < TARGET)
        begin
            if (phase < 10)
                v = size_plan[phase];
            else if ($urandom_range(0, 9) == 0)
                v = $urandom_range(0, 31);
            else
                v = $urandom_range(1, 6);
            write_size(v);
            if (phase == 1)
            begin
                // long sink hold-off while rows keep coming
                hold_req = 1'b1;
                for (int k = 0; k < 3; k++)
                    request_row($urandom_range(0, cur_size - 1));
            end
            run_phase();
            phase++;
        end

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[integer_matrix_multiply] OK");
        else
            $display("[integer_matrix_multiply] ERROR");
        $finish;
    end

endmodule
